[hw/rtl/f2d_pkg.sv]
// f2d_pkg: shared types, constants and weight function for the float to
// decimal fixed converter. No dependencies; imported by every f2d module.
package f2d_pkg;

  // Only the first 26 fraction bits can carry weight: 100000000 >> 27 is zero.
  localparam int FRAC_WIN_W  = 26;
  localparam int CELL_BITS   = 4;
  localparam int NUM_CELLS   = (FRAC_WIN_W + CELL_BITS - 1) / CELL_BITS;
  localparam int DIGIT_SCALE = 100000000;
  localparam int DIGITS_W    = 27;
  localparam int INTEGRAL_W  = 32;

  typedef enum logic [1:0] {
    ST_FINITE    = 2'd0,
    ST_INFINITY  = 2'd1,
    ST_TOO_LARGE = 2'd2
  } f2d_status_e;

  typedef enum logic [1:0] {
    FMT_SINGLE   = 2'd0,
    FMT_DOUBLE   = 2'd1,
    FMT_EXTENDED = 2'd2
  } f2d_format_e;

  // Payload handed from stage to stage.
  typedef struct packed {
    f2d_status_e             status;
    logic                    negative;
    logic [INTEGRAL_W-1:0]   integral;
    logic [DIGITS_W-1:0]     digits;
    logic [FRAC_WIN_W-1:0]   win;   // MSB is the first bit below the point
  } f2d_item_t;

  // Weight of fraction bit k (k = 1 is the first bit below the point).
  function automatic logic [DIGITS_W-1:0] cell_weight(input int k);
    logic [DIGITS_W-1:0] w;
    w = '0;
    if (k >= 1 && k <= FRAC_WIN_W) begin
      w = DIGITS_W'(DIGIT_SCALE >> k);
    end
    return w;
  endfunction

endpackage

[hw/rtl/float_to_decimal_fixed_converter.sv]
// float_to_decimal_fixed_converter: top level; decode stage followed by a
// chain of digit cells. Depends on f2d_pkg, f2d_front and f2d_cell.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one value split into
//   fraction, unbiased exponent, sign and format. Output channel
//   (out_valid_o / out_ready_i) returns status, sign, 32-bit integral part
//   and eight decimal fraction digits, one result per transaction, in order.
//   Throughput: one transaction per cycle while in_ready_o is high; the
//   decode stage and each of the seven cells are a register stage with its
//   own valid bit, each cell adding the weights of up to four fraction bits.
//   Stall: when out_ready_i is low the last stage holds its result; the
//   stages upstream keep filling empty slots, so in_ready_o drops only once
//   every stage is occupied. in_ready_o is a combinational function of
//   out_ready_i and the stage valid bits.
//   Reset: rst_ni (asynchronous, active low) empties all stages; the block
//   is ready in the first cycle after reset.
module float_to_decimal_fixed_converter #(
  parameter int INTEGRAL_EXP_LIMIT = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        fraction_bits_i,
  input  logic signed [15:0] unbiased_exponent_i,
  input  logic               sign_bit_i,
  input  logic [1:0]         format_kind_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic               negative_o,
  output logic [31:0]        integral_part_o,
  output logic [26:0]        fraction_digits_o
);
  import f2d_pkg::*;

  logic      valid_s [NUM_CELLS+1];
  logic      ready_s [NUM_CELLS+1];
  f2d_item_t data_s  [NUM_CELLS+1];

  f2d_front #(
    .INTEGRAL_EXP_LIMIT(INTEGRAL_EXP_LIMIT)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .fraction_bits_i    (fraction_bits_i),
    .unbiased_exponent_i(unbiased_exponent_i),
    .sign_bit_i         (sign_bit_i),
    .format_kind_i      (format_kind_i),
    .out_valid_o        (valid_s[0]),
    .out_ready_i        (ready_s[0]),
    .out_data_o         (data_s[0])
  );

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    f2d_cell #(
      .CELL_IDX(c)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (valid_s[c]),
      .in_ready_o (ready_s[c]),
      .in_data_i  (data_s[c]),
      .out_valid_o(valid_s[c+1]),
      .out_ready_i(ready_s[c+1]),
      .out_data_o (data_s[c+1])
    );
  end

  assign ready_s[NUM_CELLS] = out_ready_i;

  assign out_valid_o       = valid_s[NUM_CELLS];
  assign status_o          = data_s[NUM_CELLS].status;
  assign negative_o        = data_s[NUM_CELLS].negative;
  assign integral_part_o   = data_s[NUM_CELLS].integral;
  assign fraction_digits_o = data_s[NUM_CELLS].digits;

  // Non-finite results carry no magnitude.
  a_nonfinite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_FINITE) |-> (integral_part_o == '0) &&
      (fraction_digits_o == '0))
    else $error("non-finite result with nonzero magnitude");

  a_too_large_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_TOO_LARGE) |-> !negative_o)
    else $error("too-large result marked negative");

  a_digits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fraction_digits_o < 27'(DIGIT_SCALE)))
    else $error("fraction digits out of range");

  // Back pressure only reaches the input once every stage is full.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while pipeline has room");

endmodule

[hw/rtl/f2d_front.sv]
// f2d_front: decode stage; classifies the exponent, builds the integral part
// and aligns the fraction window. Depends on f2d_pkg.
module f2d_front #(
  parameter int INTEGRAL_EXP_LIMIT = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        fraction_bits_i,
  input  logic signed [15:0] unbiased_exponent_i,
  input  logic               sign_bit_i,
  input  logic [1:0]         format_kind_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output f2d_pkg::f2d_item_t out_data_o
);
  import f2d_pkg::*;

  logic              valid_q;
  f2d_item_t         data_q, data_d;
  logic [5:0]        mb;
  logic signed [15:0] emax;
  logic [63:0]       low_mask;
  logic [63:0]       mant;
  logic [63:0]       frac_neg;
  logic [63:0]       fs;
  logic [5:0]        sh;
  logic              shift_out;
  logic [6:0]        e7;
  logic [6:0]        mb7;
  logic              pos_fit;
  logic [FRAC_WIN_W-1:0] win_neg, win_pos;
  logic [INTEGRAL_W-1:0] int_pos;

  always_comb begin
    case (format_kind_i)
      FMT_SINGLE: begin
        mb   = 6'd23;
        emax = 16'sd128;
      end
      FMT_DOUBLE: begin
        mb   = 6'd52;
        emax = 16'sd1024;
      end
      default: begin
        mb   = 6'd63;
        emax = 16'sd16384;
      end
    endcase
  end

  always_comb begin
    low_mask  = (64'd1 << mb) - 64'd1;
    mant      = (fraction_bits_i & low_mask) | (64'd1 << mb);
    // negative exponent: stray bits above the fraction stay in play
    frac_neg  = fraction_bits_i | (64'd1 << mb);
    sh        = 6'(-unbiased_exponent_i);
    shift_out = (unbiased_exponent_i < -16'sd63);
    fs        = shift_out ? 64'd0 : (frac_neg >> sh);
    win_neg   = FRAC_WIN_W'({fs, {FRAC_WIN_W{1'b0}}} >> mb);

    e7      = unbiased_exponent_i[6:0];
    mb7     = {1'b0, mb};
    pos_fit = (e7 <= mb7);
    win_pos = pos_fit ? FRAC_WIN_W'({fraction_bits_i, {FRAC_WIN_W{1'b0}}} >> (mb7 - e7))
                      : '0;
    int_pos = pos_fit ? INTEGRAL_W'(mant >> (mb7 - e7)) : INTEGRAL_W'(mant << (e7 - mb7));
  end

  always_comb begin
    data_d.digits = '0;
    if (unbiased_exponent_i == emax) begin
      data_d.status   = ST_INFINITY;
      data_d.negative = sign_bit_i;
      data_d.integral = '0;
      data_d.win      = '0;
    end else if (unbiased_exponent_i > $signed(16'(INTEGRAL_EXP_LIMIT))) begin
      data_d.status   = ST_TOO_LARGE;
      data_d.negative = 1'b0;
      data_d.integral = '0;
      data_d.win      = '0;
    end else if (unbiased_exponent_i[15]) begin
      data_d.status   = ST_FINITE;
      data_d.negative = sign_bit_i;
      data_d.integral = '0;
      data_d.win      = win_neg;
    end else begin
      data_d.status   = ST_FINITE;
      data_d.negative = sign_bit_i;
      data_d.integral = int_pos;
      data_d.win      = win_pos;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[hw/rtl/f2d_cell.sv]
// f2d_cell: one stage of the digit chain; adds the weights of its group of
// fraction bits to the running digit sum. Depends on f2d_pkg.
module f2d_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  f2d_pkg::f2d_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output f2d_pkg::f2d_item_t out_data_o
);
  import f2d_pkg::*;

  logic                valid_q;
  f2d_item_t           data_q, data_d;
  logic [DIGITS_W-1:0] acc;

  always_comb begin
    acc = in_data_i.digits;
    for (int j = 0; j < CELL_BITS; j++) begin
      if (CELL_IDX * CELL_BITS + j < FRAC_WIN_W) begin
        if (in_data_i.win[FRAC_WIN_W - 1 - (CELL_IDX * CELL_BITS + j)]) begin
          acc = acc + cell_weight(CELL_IDX * CELL_BITS + j + 1);
        end
      end
    end
    data_d        = in_data_i;
    data_d.digits = acc;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
